/* src/vpi_pkg.sv */
// Shared types and constants for the video port interface.
`default_nettype none
package vpi_pkg;

    typedef enum logic [2:0] {
        REQ_DATA_WR    = 3'd0,
        REQ_CTRL_WR    = 3'd1,
        REQ_DATA_RD    = 3'd2,
        REQ_STATUS_RD  = 3'd3,
        REQ_HBLANK_SET = 3'd4,
        REQ_HBLANK_CLR = 3'd5,
        REQ_VBLANK_SET = 3'd6,
        REQ_VBLANK_CLR = 3'd7
    } t_req;

    // classified bus transaction passed from front to back
    typedef struct packed {
        t_req        req;
        logic        reg_form;
        logic [4:0]  reg_idx;
        logic [15:0] word;
    } t_item;

    localparam int ITEM_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH  = 4;
    localparam int VADDR_EXT_BITS   = 17;

    localparam logic [15:0] STATUS_RESET  = 16'h3400;
    localparam logic [15:0] MASK_COLOUR   = 16'h0EEE;
    localparam logic [15:0] MASK_SCROLL   = 16'h07FF;
    localparam logic [15:0] MASK_BYTE     = 16'h00FF;
    localparam logic [15:0] BAD_READ      = 16'h00FF;
    localparam logic [15:0] FORM_MASK     = 16'hC000;
    localparam logic [15:0] REG_FORM      = 16'h8000;
    localparam logic [15:0] ADDR_LOW_MASK = 16'h3FFF;
    localparam logic [5:0]  CODE_KEEP     = 6'h3C;
    localparam logic [5:0]  SCROLL_LIMIT  = 6'h28;

    localparam logic [3:0] CODE_VIDEO_WR  = 4'h1;
    localparam logic [3:0] CODE_COLOUR_WR = 4'h3;
    localparam logic [3:0] CODE_SCROLL_WR = 4'h5;
    localparam logic [3:0] CODE_VIDEO_RD  = 4'h0;
    localparam logic [3:0] CODE_SCROLL_RD = 4'h4;
    localparam logic [3:0] CODE_COLOUR_RD = 4'h8;
    localparam logic [3:0] CODE_BYTE_RD   = 4'hC;

    localparam logic [4:0] REG_MODE      = 5'd1;
    localparam logic [4:0] REG_STEP      = 5'd15;
    localparam logic [4:0] REG_MODE_LIMIT = 5'd10;
    localparam int         MODE_BIT      = 2;
    localparam int         HBLANK_BIT    = 2;
    localparam int         VBLANK_BIT    = 3;

endpackage
`default_nettype wire

/* src/vpi_front.sv */
// Input queue: accepts bus transactions and classifies them for the back end.
`default_nettype none
module vpi_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [2:0]           i_req_type,
    input  wire logic [15:0]          i_bus_word,
    input  wire logic                 i_hold,
    output logic                      o_full,
    output vpi_pkg::t_item            o_item,
    output logic                      o_valid,
    input  wire logic                 i_pop
);
    localparam int PW = (vpi_pkg::ITEM_QUEUE_DEPTH > 1) ? $clog2(vpi_pkg::ITEM_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(vpi_pkg::ITEM_QUEUE_DEPTH + 1);

    vpi_pkg::t_item r_q [vpi_pkg::ITEM_QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    vpi_pkg::t_item in_item;
    logic           do_push;
    logic           do_pop;

    always_comb begin
        in_item.req      = vpi_pkg::t_req'(i_req_type);
        in_item.reg_form = (i_bus_word & vpi_pkg::FORM_MASK) == vpi_pkg::REG_FORM;
        in_item.reg_idx  = i_bus_word[12:8];
        in_item.word     = i_bus_word;
    end

    assign o_full  = (r_count == CW'(vpi_pkg::ITEM_QUEUE_DEPTH)) || i_hold;
    assign o_valid = r_count != '0;
    assign o_item  = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(vpi_pkg::ITEM_QUEUE_DEPTH - 1)) ? '0
                                                                              : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(vpi_pkg::ITEM_QUEUE_DEPTH - 1)) ? '0
                                                                              : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule
`default_nettype wire

/* src/vpi_rfifo.sv */
// Result queue holding read words until they are popped.
`default_nettype none
module vpi_rfifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [15:0]          i_data,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output logic [15:0]               o_data,
    output logic [$clog2(vpi_pkg::RES_QUEUE_DEPTH + 1)-1:0] o_count
);
    localparam int PW = $clog2(vpi_pkg::RES_QUEUE_DEPTH);
    localparam int CW = $clog2(vpi_pkg::RES_QUEUE_DEPTH + 1);

    logic [15:0]   r_q [vpi_pkg::RES_QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_empty = r_count == '0;
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end
endmodule
`default_nettype wire

/* src/vpi_back.sv */
// Execution back end: command state, setting registers, memories and read merge.
`default_nettype none
module vpi_back #(
    parameter int VIDEO_ADDR_BITS = 16,
    parameter int COLOUR_DEPTH    = 64,
    parameter int SCROLL_DEPTH    = 64,
    parameter int HISTORY_DEPTH   = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire vpi_pkg::t_item       i_item,
    input  wire logic                 i_item_valid,
    output logic                      o_item_pop,
    input  wire logic [$clog2(vpi_pkg::RES_QUEUE_DEPTH + 1)-1:0] i_res_count,
    output logic                      o_res_push,
    output logic [15:0]               o_res_data,
    output logic                      o_busy
);
    localparam int VB  = VIDEO_ADDR_BITS - 1;
    localparam int CIW = $clog2(COLOUR_DEPTH);
    localparam int SIW = $clog2(SCROLL_DEPTH);
    localparam int RCW = $clog2(vpi_pkg::RES_QUEUE_DEPTH + 1);
    localparam int XW  = vpi_pkg::VADDR_EXT_BITS;

    typedef enum logic [2:0] {
        RK_IMM,
        RK_VIDEO16,
        RK_VIDEO8,
        RK_COLOUR,
        RK_SCROLL
    } t_rkind;

    // command and register state
    logic [5:0]  r_code;
    logic [15:0] r_addr;
    logic        r_due;
    logic [15:0] r_status;
    logic [7:0]  r_regs [32];
    logic [15:0] r_hist [HISTORY_DEPTH];

    // memories: video split into even and odd byte banks
    logic [7:0]  r_even_mem [2**VB];
    logic [7:0]  r_odd_mem  [2**VB];
    logic [15:0] r_colour_mem [COLOUR_DEPTH];
    logic [15:0] r_scroll_mem [SCROLL_DEPTH];

    logic [7:0]  r_even_q;
    logic [7:0]  r_odd_q;
    logic [15:0] r_colour_q;
    logic [15:0] r_scroll_q;

    // merge stage
    logic        r_b_valid;
    t_rkind      r_b_kind;
    logic [15:0] r_b_imm;
    logic [15:0] r_b_oldest;
    logic        r_b_odd;

    // clearing pass
    logic          r_clr_busy;
    logic [VB-1:0] r_clr_cnt;

    logic          issue;
    logic [15:0]   step_addr;
    logic [XW-1:0] a_hi;
    logic [XW-1:0] a_lo;
    logic [VB-1:0] rd_idx;
    logic [5:0]    small_idx;
    logic [5:0]    scroll_rd_raw;
    logic [5:0]    colour_wrap;
    logic [5:0]    scroll_wr_wrap;
    logic [5:0]    scroll_rd_wrap;
    logic [CIW-1:0] colour_idx;
    logic [SIW-1:0] scroll_wr_idx;
    logic [SIW-1:0] scroll_rd_idx;
    logic          is_video_wr;
    logic          is_colour_wr;
    logic          is_scroll_wr;
    logic          even_we;
    logic [VB-1:0] even_widx;
    logic [7:0]    even_wd;
    logic          odd_we;
    logic [VB-1:0] odd_widx;
    logic [7:0]    odd_wd;
    logic          colour_we;
    logic [CIW-1:0] colour_widx;
    logic [15:0]   colour_wd;
    logic          scroll_we;
    logic [SIW-1:0] scroll_widx;
    logic [15:0]   scroll_wd;
    logic          reg_blocked;
    logic          n_valid;
    t_rkind        n_kind;
    logic [15:0]   n_imm;
    logic          n_step;

    // index modulo a depth of at least 16 for a 6-bit index
    function automatic logic [5:0] wrap6(input logic [5:0] v, input logic [6:0] d);
        logic [5:0] t;
        t = v;
        for (int k = 0; k < 4; k++) begin
            if ({1'b0, t} >= d) begin
                t = t - d[5:0];
            end
        end
        return t;
    endfunction

    function automatic logic [15:0] merge(input logic [15:0] v, input logic [15:0] keep,
                                          input logic [15:0] old);
        return (v & keep) | (old & ~keep);
    endfunction

    assign issue = i_item_valid && !r_clr_busy &&
                   (({1'b0, i_res_count} + (RCW + 1)'(r_b_valid))
                    < (RCW + 1)'(vpi_pkg::RES_QUEUE_DEPTH));
    assign o_item_pop = issue;
    assign o_busy     = r_clr_busy;

    assign step_addr = r_addr + {8'h00, r_regs[vpi_pkg::REG_STEP]};
    assign a_hi      = {1'b0, r_addr};
    assign a_lo      = a_hi + XW'(1);
    assign rd_idx    = a_hi[VB:1];
    assign small_idx = r_addr[6:1];

    assign scroll_rd_raw  = (small_idx >= vpi_pkg::SCROLL_LIMIT) ? 6'd0 : small_idx;
    assign colour_wrap    = wrap6(small_idx, 7'(COLOUR_DEPTH));
    assign scroll_wr_wrap = wrap6(small_idx, 7'(SCROLL_DEPTH));
    assign scroll_rd_wrap = wrap6(scroll_rd_raw, 7'(SCROLL_DEPTH));
    assign colour_idx     = colour_wrap[CIW-1:0];
    assign scroll_wr_idx  = scroll_wr_wrap[SIW-1:0];
    assign scroll_rd_idx  = scroll_rd_wrap[SIW-1:0];

    assign reg_blocked = !r_regs[vpi_pkg::REG_MODE][vpi_pkg::MODE_BIT] &&
                         (i_item.reg_idx > vpi_pkg::REG_MODE_LIMIT);

    always_comb begin
        is_video_wr  = 1'b0;
        is_colour_wr = 1'b0;
        is_scroll_wr = 1'b0;
        n_valid      = issue;
        n_kind       = RK_IMM;
        n_imm        = 16'h0000;
        n_step       = 1'b0;
        if (issue) begin
            case (i_item.req)
                vpi_pkg::REQ_DATA_WR: begin
                    case (r_code[3:0])
                        vpi_pkg::CODE_VIDEO_WR:  is_video_wr  = 1'b1;
                        vpi_pkg::CODE_COLOUR_WR: is_colour_wr = 1'b1;
                        vpi_pkg::CODE_SCROLL_WR: is_scroll_wr = 1'b1;
                        default: ;
                    endcase
                    n_step = is_video_wr || is_colour_wr || is_scroll_wr;
                end
                vpi_pkg::REQ_DATA_RD: begin
                    n_step = 1'b1;
                    case (r_code[3:0])
                        vpi_pkg::CODE_VIDEO_RD:  n_kind = RK_VIDEO16;
                        vpi_pkg::CODE_SCROLL_RD: n_kind = RK_SCROLL;
                        vpi_pkg::CODE_COLOUR_RD: n_kind = RK_COLOUR;
                        vpi_pkg::CODE_BYTE_RD:   n_kind = RK_VIDEO8;
                        default: begin
                            n_imm  = vpi_pkg::BAD_READ;
                            n_step = 1'b0;
                        end
                    endcase
                end
                vpi_pkg::REQ_STATUS_RD: n_imm = r_status;
                default: ;
            endcase
        end
    end

    // memory write ports; the clearing pass owns them after reset
    always_comb begin
        if (r_clr_busy) begin
            even_we     = 1'b1;
            even_widx   = r_clr_cnt;
            even_wd     = 8'h00;
            odd_we      = 1'b1;
            odd_widx    = r_clr_cnt;
            odd_wd      = 8'h00;
            colour_we   = r_clr_cnt < VB'(COLOUR_DEPTH);
            colour_widx = r_clr_cnt[CIW-1:0];
            colour_wd   = 16'h0000;
            scroll_we   = r_clr_cnt < VB'(SCROLL_DEPTH);
            scroll_widx = r_clr_cnt[SIW-1:0];
            scroll_wd   = 16'h0000;
        end else begin
            even_we     = is_video_wr;
            odd_we      = is_video_wr;
            if (!a_hi[0]) begin
                even_widx = a_hi[VB:1];
                even_wd   = i_item.word[15:8];
                odd_widx  = a_lo[VB:1];
                odd_wd    = i_item.word[7:0];
            end else begin
                odd_widx  = a_hi[VB:1];
                odd_wd    = i_item.word[15:8];
                even_widx = a_lo[VB:1];
                even_wd   = i_item.word[7:0];
            end
            colour_we   = is_colour_wr;
            colour_widx = colour_idx;
            colour_wd   = i_item.word;
            scroll_we   = is_scroll_wr;
            scroll_widx = scroll_wr_idx;
            scroll_wd   = i_item.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (even_we) begin
            r_even_mem[even_widx] <= even_wd;
        end
        r_even_q <= r_even_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (odd_we) begin
            r_odd_mem[odd_widx] <= odd_wd;
        end
        r_odd_q <= r_odd_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (colour_we) begin
            r_colour_mem[colour_widx] <= colour_wd;
        end
        r_colour_q <= r_colour_mem[colour_idx];
    end

    always_ff @(posedge i_clk) begin
        if (scroll_we) begin
            r_scroll_mem[scroll_widx] <= scroll_wd;
        end
        r_scroll_q <= r_scroll_mem[scroll_rd_idx];
    end

    // merge-stage payload
    always_ff @(posedge i_clk) begin
        r_b_kind   <= n_kind;
        r_b_imm    <= n_imm;
        r_b_oldest <= r_hist[HISTORY_DEPTH-1];
        r_b_odd    <= !r_addr[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code     <= '0;
            r_addr     <= '0;
            r_due      <= 1'b0;
            r_status   <= vpi_pkg::STATUS_RESET;
            r_b_valid  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            for (int i = 0; i < 32; i++) begin
                r_regs[i] <= 8'h00;
            end
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= 16'h0000;
            end
        end else begin
            r_b_valid <= n_valid;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (n_step) begin
                r_addr <= step_addr;
            end
            if (issue) begin
                case (i_item.req)
                    vpi_pkg::REQ_DATA_WR: begin
                        r_due <= 1'b0;
                        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                            r_hist[i] <= r_hist[i-1];
                        end
                        r_hist[0] <= i_item.word;
                    end
                    vpi_pkg::REQ_DATA_RD: r_due <= 1'b0;
                    vpi_pkg::REQ_CTRL_WR: begin
                        if (!r_due) begin
                            if (i_item.reg_form) begin
                                if (!reg_blocked) begin
                                    r_regs[i_item.reg_idx] <= i_item.word[7:0];
                                    r_code <= r_code & vpi_pkg::CODE_KEEP;
                                    r_addr <= r_addr & vpi_pkg::FORM_MASK;
                                end
                            end else begin
                                r_code <= {r_code[5:2], i_item.word[15:14]};
                                r_addr <= (r_addr & vpi_pkg::FORM_MASK) |
                                          (i_item.word & vpi_pkg::ADDR_LOW_MASK);
                                r_due  <= 1'b1;
                            end
                        end else begin
                            r_code <= {i_item.word[7:4], r_code[1:0]};
                            r_addr <= {i_item.word[1:0], r_addr[13:0]};
                            r_due  <= 1'b0;
                        end
                    end
                    vpi_pkg::REQ_HBLANK_SET: r_status[vpi_pkg::HBLANK_BIT] <= 1'b1;
                    vpi_pkg::REQ_HBLANK_CLR: r_status[vpi_pkg::HBLANK_BIT] <= 1'b0;
                    vpi_pkg::REQ_VBLANK_SET: r_status[vpi_pkg::VBLANK_BIT] <= 1'b1;
                    vpi_pkg::REQ_VBLANK_CLR: r_status[vpi_pkg::VBLANK_BIT] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    assign o_res_push = r_b_valid;

    always_comb begin
        case (r_b_kind)
            RK_VIDEO16: o_res_data = {r_even_q, r_odd_q};
            RK_VIDEO8:  o_res_data = merge({8'h00, r_b_odd ? r_odd_q : r_even_q},
                                           vpi_pkg::MASK_BYTE, r_b_oldest);
            RK_COLOUR:  o_res_data = merge(r_colour_q, vpi_pkg::MASK_COLOUR, r_b_oldest);
            RK_SCROLL:  o_res_data = merge(r_scroll_q, vpi_pkg::MASK_SCROLL, r_b_oldest);
            default:    o_res_data = r_b_imm;
        endcase
    end
endmodule
`default_nettype wire

/* src/video_port_interface.sv */
// Top level of the video port interface: input queue, back end and result queue.
// One bus transaction (data/control write, data/status read, blanking event) is taken
// per cycle while full is low, and each yields one read word; on its way to the result
// queue the transaction passes through the input queue and the registered read of the
// memory port in the back end, whose history merge feeds the result queue in the same
// cycle. After reset, full stays high while video, colour and scroll memory are
// cleared one row per cycle. The result queue holds four words; push stalls once it
// (with the word in the merge stage) and the two-entry input queue are both filled,
// and while the memory is cleared after reset.
`default_nettype none
module video_port_interface #(
    parameter int VIDEO_ADDR_BITS = 16,
    parameter int COLOUR_DEPTH    = 64,
    parameter int SCROLL_DEPTH    = 64,
    parameter int HISTORY_DEPTH   = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [15:0] i_bus_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_read_word
);
    vpi_pkg::t_item item;
    logic           item_valid;
    logic           item_pop;
    logic           busy;
    logic           res_push;
    logic [15:0]    res_data;
    logic [$clog2(vpi_pkg::RES_QUEUE_DEPTH + 1)-1:0] res_count;

    vpi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_bus_word (i_bus_word),
        .i_hold     (busy),
        .o_full     (full),
        .o_item     (item),
        .o_valid    (item_valid),
        .i_pop      (item_pop)
    );

    vpi_back #(
        .VIDEO_ADDR_BITS (VIDEO_ADDR_BITS),
        .COLOUR_DEPTH    (COLOUR_DEPTH),
        .SCROLL_DEPTH    (SCROLL_DEPTH),
        .HISTORY_DEPTH   (HISTORY_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_res_count  (res_count),
        .o_res_push   (res_push),
        .o_res_data   (res_data),
        .o_busy       (busy)
    );

    vpi_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_read_word),
        .o_count (res_count)
    );
endmodule
`default_nettype wire

/* verif/video_port_interface_tb.sv */
// Self-checking testbench for the video port interface: directed, random and stall tests.
`timescale 1ns / 1ps
`default_nettype none
module video_port_interface_tb;

    localparam int VIDEO_ADDR_BITS = 16;
    localparam int COLOUR_DEPTH    = 64;
    localparam int SCROLL_DEPTH    = 64;
    localparam int HISTORY_DEPTH   = 4;
    localparam int VIDEO_WORDS     = 1 << VIDEO_ADDR_BITS;

    localparam int RANDOM_ITEMS    = 1750;
    localparam int PRESSURE_HOLD   = 400;
    localparam int DRAIN_CYCLES    = 8;
    // longest quiet stretch is the memory clear after reset
    localparam int WATCHDOG_LIMIT  = 150000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_req_type = 3'd0;
    logic [15:0] i_bus_word = 16'h0000;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_read_word;

    // shadow of the port state
    logic [5:0]  port_code;
    logic [15:0] port_addr;
    logic        port_second_due;
    logic [15:0] port_status;
    logic [7:0]  port_regs [32];
    logic [15:0] port_history [HISTORY_DEPTH];
    logic [7:0]  port_vram [VIDEO_WORDS];
    logic [15:0] port_cram [COLOUR_DEPTH];
    logic [15:0] port_vsram [SCROLL_DEPTH];

    logic [15:0] expected_words [$];
    int items_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int hold_requests = 0;
    int idle_cycles = 0;
    logic no_idle = 1'b0;

    video_port_interface #(
        .VIDEO_ADDR_BITS(VIDEO_ADDR_BITS),
        .COLOUR_DEPTH   (COLOUR_DEPTH),
        .SCROLL_DEPTH   (SCROLL_DEPTH),
        .HISTORY_DEPTH  (HISTORY_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req_type (i_req_type),
        .i_bus_word (i_bus_word),
        .empty      (empty),
        .pop        (pop),
        .o_read_word(o_read_word)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_port_state();
        int k;
        port_code = '0;
        port_addr = '0;
        port_second_due = 1'b0;
        port_status = vpi_pkg::STATUS_RESET;
        for (k = 0; k < 32; k++) port_regs[k] = '0;
        for (k = 0; k < HISTORY_DEPTH; k++) port_history[k] = '0;
        for (k = 0; k < VIDEO_WORDS; k++) port_vram[k] = '0;
        for (k = 0; k < COLOUR_DEPTH; k++) port_cram[k] = '0;
        for (k = 0; k < SCROLL_DEPTH; k++) port_vsram[k] = '0;
    endtask

    // memory bits a read cannot supply come from the oldest buffered write
    function automatic logic [15:0] merge_oldest(input logic [15:0] v, input logic [15:0] keep);
        return (v & keep) | (port_history[HISTORY_DEPTH-1] & ~keep);
    endfunction

    // apply one bus transaction to the shadow state, return the word it reads
    function automatic logic [15:0] port_access(input vpi_pkg::t_req req,
                                                input logic [15:0] word);
        logic [15:0] rd;
        logic [5:0]  idx;
        logic [4:0]  ridx;
        logic        stepped;
        int k;
        rd = '0;
        stepped = 1'b0;
        idx = port_addr[6:1];
        case (req)
            vpi_pkg::REQ_DATA_WR: begin
                port_second_due = 1'b0;
                for (k = HISTORY_DEPTH - 1; k > 0; k--) port_history[k] = port_history[k-1];
                port_history[0] = word;
                case (port_code[3:0])
                    vpi_pkg::CODE_VIDEO_WR: begin
                        port_vram[port_addr] = word[15:8];
                        port_vram[16'(port_addr + 16'd1)] = word[7:0];
                        stepped = 1'b1;
                    end
                    vpi_pkg::CODE_COLOUR_WR: begin
                        port_cram[int'(idx) % COLOUR_DEPTH] = word;
                        stepped = 1'b1;
                    end
                    vpi_pkg::CODE_SCROLL_WR: begin
                        port_vsram[int'(idx) % SCROLL_DEPTH] = word;
                        stepped = 1'b1;
                    end
                    default: ;
                endcase
            end
            vpi_pkg::REQ_DATA_RD: begin
                port_second_due = 1'b0;
                stepped = 1'b1;
                case (port_code[3:0])
                    vpi_pkg::CODE_VIDEO_RD:
                        rd = {port_vram[{port_addr[15:1], 1'b0}],
                              port_vram[{port_addr[15:1], 1'b1}]};
                    vpi_pkg::CODE_SCROLL_RD: begin
                        if (idx >= vpi_pkg::SCROLL_LIMIT) idx = '0;
                        rd = merge_oldest(port_vsram[int'(idx) % SCROLL_DEPTH],
                                          vpi_pkg::MASK_SCROLL);
                    end
                    vpi_pkg::CODE_COLOUR_RD:
                        rd = merge_oldest(port_cram[int'(idx) % COLOUR_DEPTH],
                                          vpi_pkg::MASK_COLOUR);
                    vpi_pkg::CODE_BYTE_RD:
                        rd = merge_oldest({8'h00, port_vram[port_addr ^ 16'h0001]},
                                          vpi_pkg::MASK_BYTE);
                    default: begin
                        rd = vpi_pkg::BAD_READ;
                        stepped = 1'b0;
                    end
                endcase
            end
            vpi_pkg::REQ_CTRL_WR: begin
                if (port_second_due) begin
                    port_code = {word[7:4], port_code[1:0]};
                    port_addr = {word[1:0], port_addr[13:0]};
                    port_second_due = 1'b0;
                end else if ((word & vpi_pkg::FORM_MASK) == vpi_pkg::REG_FORM) begin
                    ridx = word[12:8];
                    // high registers are locked out until the mode bit is set
                    if (port_regs[vpi_pkg::REG_MODE][vpi_pkg::MODE_BIT] ||
                        ridx <= vpi_pkg::REG_MODE_LIMIT) begin
                        port_regs[ridx] = word[7:0];
                        port_code = port_code & vpi_pkg::CODE_KEEP;
                        port_addr = port_addr & vpi_pkg::FORM_MASK;
                    end
                end else begin
                    port_code = (port_code & vpi_pkg::CODE_KEEP) | {4'b0000, word[15:14]};
                    port_addr = (port_addr & vpi_pkg::FORM_MASK) |
                                (word & vpi_pkg::ADDR_LOW_MASK);
                    port_second_due = 1'b1;
                end
            end
            vpi_pkg::REQ_STATUS_RD:  rd = port_status;
            vpi_pkg::REQ_HBLANK_SET: port_status[vpi_pkg::HBLANK_BIT] = 1'b1;
            vpi_pkg::REQ_HBLANK_CLR: port_status[vpi_pkg::HBLANK_BIT] = 1'b0;
            vpi_pkg::REQ_VBLANK_SET: port_status[vpi_pkg::VBLANK_BIT] = 1'b1;
            default:                 port_status[vpi_pkg::VBLANK_BIT] = 1'b0;
        endcase
        if (stepped) port_addr = port_addr + {8'h00, port_regs[vpi_pkg::REG_STEP]};
        return rd;
    endfunction

    // push stays high across back-to-back transactions
    task automatic send_item(input vpi_pkg::t_req req, input logic [15:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req_type <= req;
        i_bus_word <= word;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_words.push_back(port_access(req, word));
        items_sent++;
    endtask

    task automatic set_reg(input logic [4:0] idx, input logic [7:0] val);
        send_item(vpi_pkg::REQ_CTRL_WR, {2'b10, 1'($urandom), idx, val});
    endtask

    // two-word command; code[1:0] must not be 2'b10 or the first word reads as a register write
    task automatic set_cmd(input logic [5:0] code, input logic [15:0] addr);
        send_item(vpi_pkg::REQ_CTRL_WR, {code[1:0], addr[13:0]});
        send_item(vpi_pkg::REQ_CTRL_WR, {8'($urandom), code[5:2], 2'($urandom), addr[15:14]});
    endtask

    task automatic test_status_and_blanking();
        send_item(vpi_pkg::REQ_STATUS_RD, 16'hFFFF);
        send_item(vpi_pkg::REQ_HBLANK_SET, 16'h0000);
        send_item(vpi_pkg::REQ_VBLANK_SET, 16'hFFFF);
        send_item(vpi_pkg::REQ_STATUS_RD, 16'h0000);
        send_item(vpi_pkg::REQ_HBLANK_CLR, 16'h5555);
        send_item(vpi_pkg::REQ_VBLANK_CLR, 16'hAAAA);
        send_item(vpi_pkg::REQ_STATUS_RD, 16'h1234);
    endtask

    task automatic test_register_lockout();
        set_cmd({2'b00, vpi_pkg::CODE_VIDEO_WR}, 16'hFFFF);
        // step register is locked while the mode bit is clear; command must survive
        set_reg(vpi_pkg::REG_STEP, 8'hFF);
        // video write at the top of memory wraps its low byte to address 0
        send_item(vpi_pkg::REQ_DATA_WR, 16'hA55A);
        set_reg(vpi_pkg::REG_MODE, 8'h04);
        set_reg(vpi_pkg::REG_STEP, 8'hFF);
        set_cmd({2'b00, vpi_pkg::CODE_VIDEO_RD}, 16'hFFFE);
        send_item(vpi_pkg::REQ_DATA_RD, 16'h0000);
    endtask

    task automatic test_memory_paths();
        set_cmd({2'b00, vpi_pkg::CODE_COLOUR_WR}, 16'h007E);
        send_item(vpi_pkg::REQ_DATA_WR, 16'hFFFF);
        set_cmd({2'b00, vpi_pkg::CODE_COLOUR_RD}, 16'h007E);
        send_item(vpi_pkg::REQ_DATA_RD, 16'h0000);
        // scroll index at or past the scroll limit reads entry 0
        set_cmd({2'b00, vpi_pkg::CODE_SCROLL_RD}, 16'h0060);
        send_item(vpi_pkg::REQ_DATA_RD, 16'h0000);
        // lone first word leaves an unused code; the read clears the half-command
        send_item(vpi_pkg::REQ_CTRL_WR, 16'hC000);
        send_item(vpi_pkg::REQ_DATA_RD, 16'hFFFF);
        set_cmd({2'b10, vpi_pkg::CODE_BYTE_RD}, 16'h0001);
        send_item(vpi_pkg::REQ_DATA_RD, 16'h0000);
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [3:0]  wr_codes [3];
        logic [3:0]  rd_codes [4];
        logic [5:0]  code;
        logic [15:0] addr;
        logic [4:0]  ridx;
        logic [7:0]  rval;
        int stop_at, roll, n, k;
        bit writing;
        wr_codes = '{vpi_pkg::CODE_VIDEO_WR, vpi_pkg::CODE_COLOUR_WR, vpi_pkg::CODE_SCROLL_WR};
        rd_codes = '{vpi_pkg::CODE_VIDEO_RD, vpi_pkg::CODE_SCROLL_RD, vpi_pkg::CODE_COLOUR_RD,
                     vpi_pkg::CODE_BYTE_RD};
        stop_at = items_sent + n_items;
        set_reg(vpi_pkg::REG_MODE, 8'h04);
        while (items_sent < stop_at) begin
            // a stretch without any idling on either side
            no_idle = (items_sent - (stop_at - n_items)) inside {[200:400]};
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                if ($urandom_range(0, 2) == 0) begin
                    if ($urandom_range(0, 4) == 0)
                        set_reg(vpi_pkg::REG_MODE, 8'($urandom) | 8'h04);
                    case ($urandom_range(0, 5))
                        0:       rval = 8'h00;
                        1:       rval = 8'h01;
                        2:       rval = 8'($urandom);
                        3:       rval = 8'hFF;
                        default: rval = 8'h02;
                    endcase
                    set_reg(vpi_pkg::REG_STEP, rval);
                end
                writing = $urandom_range(0, 1);
                code[5:4] = 2'($urandom);
                code[3:0] = writing ? wr_codes[$urandom_range(0, 2)]
                                    : rd_codes[$urandom_range(0, 3)];
                case ($urandom_range(0, 3))
                    0, 1:    addr = 16'($urandom_range(0, 127));
                    2:       addr = 16'hFF80 | 16'($urandom_range(0, 127));
                    default: addr = 16'($urandom);
                endcase
                set_cmd(code, addr);
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    send_item(writing ? vpi_pkg::REQ_DATA_WR : vpi_pkg::REQ_DATA_RD,
                              16'($urandom));
            end else if (roll < 72) begin
                ridx = 5'($urandom);
                rval = 8'($urandom);
                if (ridx == vpi_pkg::REG_MODE && $urandom_range(0, 3) != 0)
                    rval[vpi_pkg::MODE_BIT] = 1'b1;
                set_reg(ridx, rval);
            end else if (roll < 85) begin
                send_item(vpi_pkg::t_req'($urandom_range(vpi_pkg::REQ_STATUS_RD,
                                                         vpi_pkg::REQ_VBLANK_CLR)),
                          16'($urandom));
            end else begin
                // noise, including unused codes and broken command pairs
                send_item(vpi_pkg::t_req'($urandom_range(0, 7)), 16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int k;
        hold_requests++;
        no_idle = 1'b1;
        for (k = 0; k < 24; k++)
            send_item(k % 3 == 0 ? vpi_pkg::REQ_STATUS_RD
                                 : vpi_pkg::t_req'($urandom_range(0, 7)), 16'($urandom));
        no_idle = 1'b0;
    endtask

    // result side: check each popped word, idle at random, honor hold requests
    initial begin : result_checker
        int stall_left, hold_left, holds_seen;
        logic [15:0] want;
        stall_left = 0;
        hold_left = 0;
        holds_seen = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("read word %h with no transaction pending",
                                              o_read_word));
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (o_read_word !== want)
                        report_mismatch($sformatf("read_word got %h expected %h",
                                                  o_read_word, want));
                end
            end
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        clear_port_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_status_and_blanking();
        test_register_lockout();
        test_memory_paths();
        test_output_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        test_output_backpressure();
        push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d bus transactions (status, blanking, register, command, memory traffic",
                 items_sent);
        $display("plus output stalls); %0d read words checked, %0d mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
